@@ design/etws_pkg.sv @@
// Shared event types and cell control codes for the event time window sorter.
`default_nettype none
package etws_pkg;

    localparam int TS_W = 48;
    localparam int EN_W = 32;
    localparam int MK_W = 8;
    localparam int CH_W = 8;
    localparam int HC_W = 5;
    localparam logic [HC_W-1:0] HOLD_RESET = 5'd4;

    typedef struct packed {
        logic [TS_W-1:0] ts;
        logic [EN_W-1:0] en;
        logic [MK_W-1:0] mk;
        logic [CH_W-1:0] ch;
    } evt_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        evt_t     evt;
    } cell_ctl_t;

endpackage
`default_nettype wire

@@ design/event_time_window_sorter_top.sv @@
// Top level: insertion-sorting cell row, batch bookkeeping and output register.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid in_ready + event fields | into block
//  out     | out_valid out_ready + fields     | out of block
//  cfg     | cfg_valid cfg_ready cfg_data     | into block
//
// An event is inserted in sorted place in the cell row as it is accepted, so items
// enter back to back while a batch fills. At batch close the row drains from
// its head one item per cycle into the output register; in_ready is low
// while those items (up to BATCH_MAX) are emitted, and out_ready low stalls the drain.
// Reset clears the counts and sets hold_reg to 4; cell contents are not reset.
`default_nettype none
module event_time_window_sorter_top
    import etws_pkg::*;
#(
    parameter int BATCH_MAX = 64,
    parameter int HOLD_MAX  = 16
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [TS_W-1:0] time_stamp,
    input  wire logic [EN_W-1:0] energy,
    input  wire logic [MK_W-1:0] marker,
    input  wire logic [CH_W-1:0] channel,
    input  wire logic            batch_end,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [TS_W-1:0]      time_stamp_out,
    output logic [EN_W-1:0]      energy_out,
    output logic [MK_W-1:0]      marker_out,
    output logic [CH_W-1:0]      channel_out,
    output logic                 last,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [HC_W-1:0] cfg_data
);

    localparam int DEPTH = BATCH_MAX + HOLD_MAX;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EW    = $clog2(BATCH_MAX + 1);
    localparam int WW    = (CW > HC_W) ? CW : HC_W;

    logic [CW-1:0]   occ_reg, occ_next;
    logic [EW-1:0]   batch_reg, batch_next;
    logic [EW-1:0]   emit_reg, emit_next;
    logic            drain_reg, drain_next;
    logic [HC_W-1:0] hold_reg, hold_next;
    logic            out_valid_reg, out_valid_next;
    evt_t            out_evt_reg, out_evt_next;
    logic            last_reg, last_next;

    logic            in_fire;
    logic            step;
    logic            close;
    logic [WW-1:0]   hold_eff;
    logic [WW-1:0]   total_w;
    logic [WW-1:0]   emit_w;
    evt_t            new_evt;
    cell_ctl_t       ctl;
    evt_t            cell_evt [DEPTH];
    logic            cell_gt  [DEPTH];

    assign in_ready  = !drain_reg;
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign step      = drain_reg && (!out_valid_reg || out_ready);
    assign close     = batch_end || (batch_reg == EW'(BATCH_MAX - 1));

    assign new_evt = '{ts: time_stamp, en: energy, mk: marker, ch: channel};

    always_comb
    begin
        ctl.evt = new_evt;
        if (in_fire)
        begin
            ctl.op = CELL_INSERT;
        end
        else if (step)
        begin
            ctl.op = CELL_SHIFT;
        end
        else
        begin
            ctl.op = CELL_HOLD;
        end
    end

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            evt_t left_evt;
            logic left_gt;
            evt_t right_evt;

            if (i == 0)
            begin : g_head
                assign left_evt = new_evt;
                assign left_gt  = 1'b0;
            end
            else
            begin : g_body
                assign left_evt = cell_evt[i-1];
                assign left_gt  = cell_gt[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign right_evt = cell_evt[i];
            end
            else
            begin : g_inner
                assign right_evt = cell_evt[i+1];
            end

            etws_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .empty     (CW'(i) >= occ_reg),
                .left_evt  (left_evt),
                .left_gt   (left_gt),
                .right_evt (right_evt),
                .evt       (cell_evt[i]),
                .gt        (cell_gt[i])
            );
        end
    endgenerate

    // Emit count for the batch that closes with this item.
    always_comb
    begin
        hold_eff = (WW'(hold_reg) > WW'(HOLD_MAX)) ? WW'(HOLD_MAX) : WW'(hold_reg);
        total_w  = WW'(occ_reg) + WW'(1);
        emit_w   = (total_w > hold_eff) ? (total_w - hold_eff) : '0;
        if (emit_w > WW'(BATCH_MAX))
        begin
            emit_w = WW'(BATCH_MAX);
        end
    end

    always_comb
    begin
        occ_next       = occ_reg;
        batch_next     = batch_reg;
        emit_next      = emit_reg;
        drain_next     = drain_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        out_evt_next   = out_evt_reg;
        last_next      = last_reg;

        if (cfg_valid && cfg_ready)
        begin
            hold_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            occ_next = occ_reg + CW'(1);
            if (close)
            begin
                batch_next = '0;
                emit_next  = emit_w[EW-1:0];
                drain_next = (emit_w != '0);
            end
            else
            begin
                batch_next = batch_reg + EW'(1);
            end
        end
        else if (step)
        begin
            // Move the head of the row into the output register.
            out_valid_next = 1'b1;
            out_evt_next   = cell_evt[0];
            last_next      = (emit_reg == EW'(1));
            occ_next       = occ_reg - CW'(1);
            emit_next      = emit_reg - EW'(1);
            if (emit_reg == EW'(1))
            begin
                drain_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            batch_reg     <= '0;
            emit_reg      <= '0;
            drain_reg     <= 1'b0;
            hold_reg      <= HOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            batch_reg     <= batch_next;
            emit_reg      <= emit_next;
            drain_reg     <= drain_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_evt_reg <= out_evt_next;
        last_reg    <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign time_stamp_out = out_evt_reg.ts;
    assign energy_out     = out_evt_reg.en;
    assign marker_out     = out_evt_reg.mk;
    assign channel_out    = out_evt_reg.ch;
    assign last           = last_reg;

endmodule
`default_nettype wire

@@ design/etws_cell.sv @@
// One slot of the sorted event row: compare, insert from the left, shift to the left.
`default_nettype none
module etws_cell
    import etws_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire logic      empty,
    input  wire evt_t      left_evt,
    input  wire logic      left_gt,
    input  wire evt_t      right_evt,
    output evt_t           evt,
    output logic           gt
);

    evt_t evt_reg;
    evt_t evt_next;

    // An empty slot sorts after everything; equal stamps stay ahead of the new item.
    assign gt  = empty || (evt_reg.ts > ctl.evt.ts);
    assign evt = evt_reg;

    always_comb
    begin
        evt_next = evt_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (gt)
                begin
                    evt_next = left_gt ? left_evt : ctl.evt;
                end
            end
            CELL_SHIFT:
            begin
                evt_next = right_evt;
            end
            default:
            begin
                evt_next = evt_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        evt_reg <= evt_next;
    end

endmodule
`default_nettype wire

@@ dv/tb_event_time_window_sorter_top.sv @@
`timescale 1ns / 100ps
// Testbench for event_time_window_sorter_top: batches of events checked against an insertion-sort predictor.
module tb_event_time_window_sorter_top;
    import etws_pkg::*;

    localparam int BATCH_MAX       = 64;
    localparam int HOLD_MAX        = 16;
    localparam int STORE_DEPTH     = BATCH_MAX + HOLD_MAX;
    localparam int DRAIN_WAIT      = 100;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int MAX_PRINTS      = 20;

    typedef struct {
        evt_t evt;
        logic fin;
    } sorted_evt_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    logic [TS_W-1:0] time_stamp = '0;
    logic [EN_W-1:0] energy = '0;
    logic [MK_W-1:0] marker = '0;
    logic [CH_W-1:0] channel = '0;
    logic            batch_end = 1'b0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [TS_W-1:0] time_stamp_out;
    logic [EN_W-1:0] energy_out;
    logic [MK_W-1:0] marker_out;
    logic [CH_W-1:0] channel_out;
    logic            last;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [HC_W-1:0] cfg_data = '0;

    // predictor state
    evt_t            window_store[STORE_DEPTH];
    int              held_n = 0;
    int              batch_n = 0;
    logic [HC_W-1:0] hold_reg = HOLD_RESET;
    sorted_evt_t     sorted_q[$];

    int              err_cnt = 0;
    int              cycle_cnt = 0;
    int              burst_left = 0;
    logic [TS_W-1:0] ts_base = '0;

    // receiver stall control
    bit              rx_hold_req = 1'b0;
    int              rx_hold_left = 0;
    int              rx_phase_left = 0;
    int              rx_mode = 0;

    event_time_window_sorter_top #(
        .BATCH_MAX (BATCH_MAX),
        .HOLD_MAX  (HOLD_MAX)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .time_stamp     (time_stamp),
        .energy         (energy),
        .marker         (marker),
        .channel        (channel),
        .batch_end      (batch_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .time_stamp_out (time_stamp_out),
        .energy_out     (energy_out),
        .marker_out     (marker_out),
        .channel_out    (channel_out),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // Append one event; on batch close merge with held events, sort and queue emissions.
    task automatic merge_event(evt_t e, logic be);
        int          pos;
        int          total;
        int          keep;
        int          emit;
        int          i;
        int          j;
        evt_t        cur;
        sorted_evt_t res;
        pos = held_n + batch_n;
        if (pos >= STORE_DEPTH)
            pos = STORE_DEPTH - 1;
        window_store[pos] = e;
        batch_n++;
        if (!be && batch_n < BATCH_MAX)
            return;
        total = held_n + batch_n;
        if (total > STORE_DEPTH)
            total = STORE_DEPTH;
        // stable insertion: equal time stamps keep arrival order
        for (i = 1; i < total; i++)
        begin
            cur = window_store[i];
            j = i;
            while (j > 0 && window_store[j-1].ts > cur.ts)
            begin
                window_store[j] = window_store[j-1];
                j--;
            end
            window_store[j] = cur;
        end
        keep = (hold_reg > HOLD_MAX) ? HOLD_MAX : int'(hold_reg);
        emit = (total > keep) ? total - keep : 0;
        if (emit > BATCH_MAX)
            emit = BATCH_MAX;
        for (i = 0; i < emit; i++)
        begin
            res.evt = window_store[i];
            res.fin = (i + 1 == emit);
            sorted_q.push_back(res);
        end
        for (i = 0; i < total - emit; i++)
            window_store[i] = window_store[i + emit];
        held_n = total - emit;
        batch_n = 0;
    endtask

    task automatic check_output();
        sorted_evt_t want;
        if (sorted_q.size() == 0)
        begin
            report_mismatch("item with nothing pending, time_stamp_out",
                            64'(time_stamp_out), '0);
            return;
        end
        want = sorted_q.pop_front();
        if (time_stamp_out !== want.evt.ts)
            report_mismatch("time_stamp_out", 64'(time_stamp_out), 64'(want.evt.ts));
        if (energy_out !== want.evt.en)
            report_mismatch("energy_out", 64'(energy_out), 64'(want.evt.en));
        if (marker_out !== want.evt.mk)
            report_mismatch("marker_out", 64'(marker_out), 64'(want.evt.mk));
        if (channel_out !== want.evt.ch)
            report_mismatch("channel_out", 64'(channel_out), 64'(want.evt.ch));
        if (last !== want.fin)
            report_mismatch("last", 64'(last), 64'(want.fin));
    endtask

    always @(posedge clk)
    begin
        evt_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_output();
            if (cfg_valid && cfg_ready)
                hold_reg = cfg_data;
            if (in_valid && in_ready)
            begin
                e.ts = time_stamp;
                e.en = energy;
                e.mk = marker;
                e.ch = channel;
                merge_event(e, batch_end);
            end
        end
    end

    // receiver: random phases of stall patterns, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_hold_req)
        begin
            rx_hold_req = 1'b0;
            rx_hold_left = PRESSURE_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_phase_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_phase_left = $urandom_range(10, 80);
            end
            rx_phase_left--;
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= (rx_phase_left % 4) != 0;
                default: out_ready <= $urandom_range(0, 7) != 0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic evt_t mk_evt(logic [TS_W-1:0] ts, logic [EN_W-1:0] en,
                                    logic [MK_W-1:0] mk, logic [CH_W-1:0] ch);
        evt_t e;
        e.ts = ts;
        e.en = en;
        e.mk = mk;
        e.ch = ch;
        return e;
    endfunction

    function automatic evt_t rand_event();
        evt_t        e;
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: e.ts = wide[TS_W-1:0];
            1: e.ts = TS_W'($urandom_range(0, 15));
            2: e.ts = '1 - TS_W'($urandom_range(0, 7));
            default:
            begin
                // mostly rising stream with some late arrivals
                ts_base = ts_base + TS_W'($urandom_range(0, 20));
                e.ts = ts_base - TS_W'($urandom_range(0, 30));
            end
        endcase
        e.en = $urandom;
        e.mk = MK_W'($urandom_range(0, 255));
        e.ch = CH_W'($urandom_range(0, 255));
        return e;
    endfunction

    // Offer one item in sender bursts; leave valid high on return.
    task automatic send_event(evt_t e, logic be);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 64)
                                                     : $urandom_range(1, 8);
        end
        in_valid   <= 1'b1;
        time_stamp <= e.ts;
        energy     <= e.en;
        marker     <= e.mk;
        channel    <= e.ch;
        batch_end  <= be;
        do @(posedge clk); while (!in_ready);
        burst_left--;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_hold(logic [HC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_batch(int len);
        int k;
        for (k = 0; k < len; k++)
            send_event(rand_event(), k == len - 1);
    endtask

    // first batch after reset only fills the hold window
    task automatic test_first_batch();
        send_event(mk_evt('1, '1, '1, '1), 1'b0);
        send_event(mk_evt('0, '0, '0, '0), 1'b0);
        send_event(mk_evt(48'd5, 32'h5555_aaaa, 8'h5a, 8'ha5), 1'b1);
    endtask

    task automatic test_ties_extremes();
        send_event(mk_evt(48'd7, 32'd1, 8'h01, 8'd1), 1'b0);
        send_event(mk_evt(48'd3, 32'd2, 8'h02, 8'd2), 1'b0);
        send_event(mk_evt(48'd7, 32'd3, 8'h03, 8'd3), 1'b0);
        send_event(mk_evt(48'd0, 32'hffff_ffff, 8'h80, 8'd4), 1'b0);
        send_event(mk_evt(48'd3, 32'd5, 8'h7f, 8'd5), 1'b0);
        send_event(mk_evt('1, 32'd6, 8'hff, 8'hff), 1'b1);
    endtask

    task automatic test_hold_zero();
        wait_drained();
        write_hold('0);
        send_event(mk_evt(48'h8000_0000_0000, 32'haaaa_5555, 8'haa, 8'h55), 1'b0);
        send_event(mk_evt(48'h7fff_ffff_ffff, 32'h0000_ffff, 8'h0f, 8'hf0), 1'b1);
    endtask

    // hold above the maximum acts as the maximum: nothing is emitted
    task automatic test_hold_clamp();
        wait_drained();
        write_hold('1);
        send_batch(2);
        send_batch(1);
    endtask

    task automatic test_hold_lowered();
        wait_drained();
        write_hold(5'd16);
        send_batch(12);
        wait_drained();
        write_hold(5'd3);
        send_batch(1);
    endtask

    task automatic test_random_batches(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_drained();
                case ($urandom_range(0, 5))
                    0:       write_hold('0);
                    1:       write_hold(5'd16);
                    2:       write_hold(HC_W'($urandom_range(17, 31)));
                    default: write_hold(HC_W'($urandom_range(1, 15)));
                endcase
            end
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
            send_batch(len);
            sent += len;
        end
    endtask

    // stall the output long enough that closed batches back up into the input
    task automatic test_backpressure();
        int b;
        wait_drained();
        write_hold(5'd4);
        rx_hold_req = 1'b1;
        for (b = 0; b < 6; b++)
            send_batch(5);
    endtask

    // full batch closes itself; with hold zero more than a batch is due, so some stay
    task automatic test_overflow_emission_limit();
        int k;
        wait_drained();
        write_hold(5'd16);
        send_batch(8);
        wait_drained();
        write_hold('0);
        for (k = 0; k < BATCH_MAX; k++)
            send_event(rand_event(), 1'b0);
        send_event(rand_event(), 1'b1);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_batch();
        test_ties_extremes();
        test_hold_zero();
        test_hold_clamp();
        test_hold_lowered();
        test_random_batches(35);
        test_backpressure();
        test_overflow_emission_limit();
        wait_drained();
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
